>>> hw/rtl/id3v2_frame_header_parser_defines.svh
// ============================================================================
// ID3v2 frame header parser - assertion macros
// Shared concurrent assertion forms, clocked on clk, held off while rst_n low.
// ============================================================================
`ifndef ID3V2_FRAME_HEADER_PARSER_DEFINES_SVH
`define ID3V2_FRAME_HEADER_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ID3FHP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ID3FHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/id3fhp_pkg.sv
// ============================================================================
// ID3v2 frame header parser - package
// Shared constants, record codes and the record and stage types.
// ============================================================================
package id3fhp_pkg;

    localparam int unsigned HDR_LEN         = 10;
    localparam int unsigned FOOTER_LEN      = 10;
    localparam int unsigned FLAG_EXT_BIT    = 6;
    localparam int unsigned FLAG_FOOTER_BIT = 4;

    localparam logic [23:0] TAG_MAGIC    = 24'h494433; // "ID3"
    localparam logic [23:0] FOOTER_MAGIC = 24'h334449; // "3DI"
    localparam logic [7:0]  ID_TEXT_LEAD = 8'h54;      // "T"
    localparam logic [31:0] ID_WXXX      = 32'h57585858;
    localparam logic [31:0] ID_APIC      = 32'h41504943;

    localparam logic [1:0] REC_FRAME   = 2'd0;
    localparam logic [1:0] REC_END_OK  = 2'd1;
    localparam logic [1:0] REC_END_BAD = 2'd2;

    localparam logic [1:0] FK_RAW     = 2'd0;
    localparam logic [1:0] FK_TEXT    = 2'd1;
    localparam logic [1:0] FK_PICTURE = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data_byte;
    } in_stage_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] frame_id;
        logic [1:0]  frame_kind;
        logic [15:0] frame_flags;
        logic [27:0] frame_size;
        logic [28:0] payload_offset;
        logic [7:0]  tag_version;
        logic [28:0] tag_length;
        logic [15:0] frame_count;
    } record_t;

endpackage

>>> hw/rtl/id3v2_frame_header_parser.sv
// ============================================================================
// ID3v2 frame header parser - top level
// Byte stream in, frame header and tag-end records out.
// ============================================================================
// Takes one stream byte per transfer and sustains one byte per clock cycle
// while no record waits untaken. The parse step between the input register
// and the result register loads each byte's record, if any, into the result
// register. A byte that produces a record waits in the input register only
// while the result register still holds an untaken record; bytes that produce
// no record pass through regardless of the output side.
module id3v2_frame_header_parser
    import id3fhp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] frame_id, [47:32] frame_flags, [75:48] frame_size,
    // [104:76] payload_offset, [112:105] tag_version, [141:113] tag_length,
    // [157:142] frame_count, [159:158] zero
    output logic [159:0] m_tdata,
    // [1:0] record_kind, [3:2] frame_kind
    output logic [3:0]   m_tuser
);

`include "id3v2_frame_header_parser_defines.svh"

    in_stage_t stage;
    record_t   step_rec;
    record_t   out_rec;
    logic      step_emit;
    logic      slot_free;
    logic      proc_fire;

    // Advance the held byte unless its record would overwrite a waiting one.
    assign proc_fire = stage.valid && (!step_emit || slot_free);

    id3fhp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (proc_fire),
        .stage    (stage)
    );

    id3fhp_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .data_byte (stage.data_byte),
        .emit      (step_emit),
        .rec       (step_rec)
    );

    id3fhp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc_fire && step_emit),
        .rec_in    (step_rec),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .rec_out   (out_rec)
    );

    assign m_tdata = {2'b00, out_rec.frame_count, out_rec.tag_length, out_rec.tag_version,
                      out_rec.payload_offset, out_rec.frame_size, out_rec.frame_flags,
                      out_rec.frame_id};
    assign m_tuser = {out_rec.frame_kind, out_rec.record_kind};

    `ID3FHP_ASSERT_SAME(a_no_overwrite, m_tvalid && !m_tready, !(proc_fire && step_emit),
        "record written over an untaken record")
    `ID3FHP_ASSERT_NEXT(a_record_shows, proc_fire && step_emit, m_tvalid,
        "produced record not presented")

endmodule

>>> hw/rtl/id3fhp_in_reg.sv
// ============================================================================
// ID3v2 frame header parser - input register
// Holds one accepted stream byte until the parse step consumes it.
// ============================================================================
module id3fhp_in_reg
    import id3fhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       take,
    output in_stage_t  stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Refill in the same cycle the held byte is consumed.
    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign stage.valid     = valid_reg;
    assign stage.data_byte = byte_reg;

endmodule

>>> hw/rtl/id3fhp_step.sv
// ============================================================================
// ID3v2 frame header parser - parse step
// Tag and frame header state with the per-byte next-state and record logic.
// ============================================================================
module id3fhp_step
    import id3fhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    output logic       emit,
    output record_t    rec
);

`include "id3v2_frame_header_parser_defines.svh"

    typedef enum logic [8:0] {
        PH_HUNT    = 9'b000000001,
        PH_HDR     = 9'b000000010,
        PH_EXT     = 9'b000000100,
        PH_EXTSKIP = 9'b000001000,
        PH_FID     = 9'b000010000,
        PH_FHDR    = 9'b000100000,
        PH_PAY     = 9'b001000000,
        PH_SKIP    = 9'b010000000,
        PH_PEND    = 9'b100000000
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [27:0] fcnt_reg,   fcnt_next;
    logic [27:0] body_reg,   body_next;
    logic [7:0]  tflags_reg, tflags_next;
    logic [7:0]  major_reg,  major_next;
    logic [28:0] pos_reg,    pos_next;
    logic [31:0] idsh_reg,   idsh_next;
    logic [31:0] szsh_reg,   szsh_next;
    logic [15:0] flsh_reg,   flsh_next;
    logic [15:0] frames_reg, frames_next;
    logic        bad_reg,    bad_next;

    logic [28:0] pos_inc;
    logic [28:0] body_end;
    logic [28:0] left_inc;
    logic [28:0] tag_end_cur;
    logic [28:0] tag_end_nx;
    logic [27:0] fcnt_inc;
    logic [27:0] fcnt_dec;
    logic [23:0] id24;
    logic [27:0] sz7;
    logic [27:0] ext_skip;
    logic [31:0] sz8;
    logic [31:0] id8;
    logic [15:0] fl8;
    logic [31:0] fid;
    logic [28:0] start_left;
    logic        do_start;
    logic        done;
    logic        is_v2;
    logic        is_v3;

    assign pos_inc     = pos_reg + 29'd1;
    assign body_end    = 29'(HDR_LEN) + {1'b0, body_reg};
    assign left_inc    = body_end - pos_inc;
    assign tag_end_cur = body_end + (tflags_reg[FLAG_FOOTER_BIT] ? 29'(FOOTER_LEN) : 29'd0);
    assign fcnt_inc    = fcnt_reg + 28'd1;
    assign fcnt_dec    = (fcnt_reg != 28'd0) ? fcnt_reg - 28'd1 : 28'd0;
    assign id24        = {idsh_reg[15:0], data_byte};
    assign sz7         = {szsh_reg[20:0], data_byte[6:0]};
    assign ext_skip    = (sz7 >= 28'd4) ? sz7 - 28'd4 : 28'd0;
    assign sz8         = {szsh_reg[23:0], data_byte};
    assign id8         = {idsh_reg[23:0], data_byte};
    assign fl8         = {flsh_reg[7:0], data_byte};
    assign is_v2       = (major_reg == 8'd2);
    assign is_v3       = (major_reg == 8'd3);

    always_comb
    begin
        phase_next  = phase_reg;
        fcnt_next   = fcnt_reg;
        body_next   = body_reg;
        tflags_next = tflags_reg;
        major_next  = major_reg;
        pos_next    = pos_reg;
        idsh_next   = idsh_reg;
        szsh_next   = szsh_reg;
        flsh_next   = flsh_reg;
        frames_next = frames_reg;
        bad_next    = bad_reg;
        emit        = 1'b0;
        rec         = '0;
        do_start    = 1'b0;
        done        = 1'b0;
        fid         = 32'd0;
        start_left  = left_inc;
        tag_end_nx  = 29'd0;

        case (phase_reg)
            PH_PEND:
            begin
                emit            = 1'b1;
                rec.record_kind = bad_reg ? REC_END_BAD : REC_END_OK;
                rec.tag_version = major_reg;
                rec.tag_length  = tag_end_cur;
                rec.frame_count = frames_reg;
                // Start a fresh hunt with this byte.
                phase_next  = PH_HUNT;
                fcnt_next   = '0;
                body_next   = '0;
                tflags_next = '0;
                major_next  = '0;
                pos_next    = '0;
                idsh_next   = {24'd0, data_byte};
                szsh_next   = '0;
                flsh_next   = '0;
                frames_next = '0;
                bad_next    = 1'b0;
            end
            PH_HUNT:
            begin
                idsh_next = {8'd0, id24};
                if (id24 == TAG_MAGIC)
                begin
                    phase_next = PH_HDR;
                    idsh_next  = '0;
                    pos_next   = 29'd3;
                end
            end
            PH_HDR:
            begin
                pos_next = pos_inc;
                case (pos_reg[3:0])
                    4'd3:    major_next  = data_byte;
                    4'd5:    tflags_next = data_byte;
                    default: ;
                endcase
                if (pos_reg[3:0] >= 4'd6)
                begin
                    szsh_next = {4'd0, sz7};
                end
                if (pos_reg[3:0] == 4'd9)
                begin
                    body_next  = sz7;
                    szsh_next  = '0;
                    start_left = {1'b0, sz7};
                    if (major_reg < 8'd2)
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else if (tflags_reg[FLAG_EXT_BIT])
                    begin
                        if (sz7 < 28'd4)
                        begin
                            bad_next   = 1'b1;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_EXT;
                            fcnt_next  = '0;
                        end
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
            end
            PH_EXT:
            begin
                pos_next  = pos_inc;
                szsh_next = {4'd0, sz7};
                fcnt_next = fcnt_inc;
                if (fcnt_inc >= 28'd4)
                begin
                    if ({1'b0, ext_skip} > left_inc)
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else if (ext_skip == 28'd0)
                    begin
                        do_start = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_EXTSKIP;
                        fcnt_next  = ext_skip;
                    end
                end
            end
            PH_EXTSKIP, PH_PAY:
            begin
                pos_next  = pos_inc;
                fcnt_next = fcnt_dec;
                if (fcnt_dec == 28'd0)
                begin
                    do_start = 1'b1;
                end
            end
            PH_FID:
            begin
                pos_next  = pos_inc;
                idsh_next = {8'd0, id24};
                fcnt_next = fcnt_inc;
                if (fcnt_inc >= 28'd3)
                begin
                    if (id24 == 24'd0 || id24 == FOOTER_MAGIC)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_FHDR;
                        fcnt_next  = '0;
                        szsh_next  = '0;
                        flsh_next  = '0;
                    end
                end
            end
            PH_FHDR:
            begin
                pos_next  = pos_inc;
                fcnt_next = fcnt_inc;
                if (is_v3 && fcnt_reg == 28'd0 && data_byte == 8'd0)
                begin
                    // Short v2.3 ID: drop it and restart on the next byte.
                    do_start = 1'b1;
                end
                else
                begin
                    if (is_v2)
                    begin
                        szsh_next = sz8;
                        done      = (fcnt_inc >= 28'd3);
                    end
                    else
                    begin
                        if (fcnt_reg == 28'd0)
                        begin
                            idsh_next = id8;
                        end
                        else if (fcnt_reg <= 28'd4)
                        begin
                            szsh_next = is_v3 ? sz8 : {4'd0, sz7};
                        end
                        else
                        begin
                            flsh_next = fl8;
                        end
                        done = (fcnt_inc >= 28'd7);
                    end
                    if (!done)
                    begin
                        if (pos_inc >= body_end)
                        begin
                            bad_next   = 1'b1;
                            phase_next = PH_SKIP;
                        end
                    end
                    else
                    begin
                        fid       = is_v2 ? {idsh_next[23:0], 8'h00} : idsh_next;
                        idsh_next = fid;
                        if (szsh_next > {3'd0, left_inc})
                        begin
                            bad_next   = 1'b1;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            frames_next = (frames_reg != 16'hFFFF) ? frames_reg + 16'd1
                                                                   : frames_reg;
                            emit               = 1'b1;
                            rec.record_kind    = REC_FRAME;
                            rec.frame_id       = fid;
                            if (fid[31:24] == ID_TEXT_LEAD || fid == ID_WXXX)
                            begin
                                rec.frame_kind = FK_TEXT;
                            end
                            else if (fid == ID_APIC)
                            begin
                                rec.frame_kind = FK_PICTURE;
                            end
                            else
                            begin
                                rec.frame_kind = FK_RAW;
                            end
                            rec.frame_flags    = flsh_next;
                            rec.frame_size     = szsh_next[27:0];
                            rec.payload_offset = pos_inc;
                            rec.tag_version    = major_reg;
                            rec.tag_length     = tag_end_cur;
                            rec.frame_count    = frames_next;
                            if (szsh_next == 32'd0)
                            begin
                                do_start = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAY;
                                fcnt_next  = szsh_next[27:0];
                            end
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                pos_next = pos_inc;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        // Open a new frame header, or drop into skip when too few bytes remain.
        if (do_start)
        begin
            if (start_left <= 29'd4)
            begin
                phase_next = PH_SKIP;
            end
            else
            begin
                phase_next = PH_FID;
                fcnt_next  = '0;
                idsh_next  = '0;
            end
        end

        tag_end_nx = 29'(HDR_LEN) + {1'b0, body_next}
                   + (tflags_next[FLAG_FOOTER_BIT] ? 29'(FOOTER_LEN) : 29'd0);

        if (phase_next == PH_SKIP && pos_next >= tag_end_nx)
        begin
            if (emit)
            begin
                // Frame record owns this byte: defer the tag-end record.
                phase_next = PH_PEND;
            end
            else
            begin
                emit            = 1'b1;
                rec             = '0;
                rec.record_kind = bad_next ? REC_END_BAD : REC_END_OK;
                rec.tag_version = major_next;
                rec.tag_length  = tag_end_nx;
                rec.frame_count = frames_next;
                phase_next  = PH_HUNT;
                fcnt_next   = '0;
                body_next   = '0;
                tflags_next = '0;
                major_next  = '0;
                pos_next    = '0;
                idsh_next   = '0;
                szsh_next   = '0;
                flsh_next   = '0;
                frames_next = '0;
                bad_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            fcnt_reg   <= '0;
            body_reg   <= '0;
            tflags_reg <= '0;
            major_reg  <= '0;
            pos_reg    <= '0;
            idsh_reg   <= '0;
            szsh_reg   <= '0;
            flsh_reg   <= '0;
            frames_reg <= '0;
            bad_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            fcnt_reg   <= fcnt_next;
            body_reg   <= body_next;
            tflags_reg <= tflags_next;
            major_reg  <= major_next;
            pos_reg    <= pos_next;
            idsh_reg   <= idsh_next;
            szsh_reg   <= szsh_next;
            flsh_reg   <= flsh_next;
            frames_reg <= frames_next;
            bad_reg    <= bad_next;
        end
    end

    `ID3FHP_ASSERT_NEXT(a_end_rec_rehunts,
        fire && emit && rec.record_kind != REC_FRAME, phase_reg == PH_HUNT,
        "tag-end record not followed by hunting")
    `ID3FHP_ASSERT_SAME(a_pend_emits, fire && phase_reg == PH_PEND, emit,
        "deferred tag-end record not emitted")
    `ID3FHP_ASSERT_SAME(a_frame_in_tag,
        fire && emit && rec.record_kind == REC_FRAME,
        (({1'b0, rec.payload_offset} + {2'b0, rec.frame_size}) <= {1'b0, rec.tag_length}),
        "frame payload runs past tag end")

endmodule

>>> hw/rtl/id3fhp_out_reg.sv
// ============================================================================
// ID3v2 frame header parser - result register
// Holds one record until the downstream side takes it.
// ============================================================================
module id3fhp_out_reg
    import id3fhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  record_t rec_in,
    output logic    slot_free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output record_t rec_out
);

    logic    valid_reg;
    logic    valid_next;
    record_t rec_reg;

    assign slot_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign rec_out  = rec_reg;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// ID3v2 frame header parser testbench
// Streams tag-shaped byte sequences, some of them well formed and some of them
// broken, through the parser. A scoreboard keeps its own model of the
// parse, queues the frame and tag-end records that it predicts, and compares
// every record the parser sends out against the oldest one waiting.
// ----------------------------------------------------------------------------
module testbench;
    import id3fhp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 650;

    typedef enum logic [8:0] {
        P_HUNT    = 9'b000000001,
        P_HDR     = 9'b000000010,
        P_EXT     = 9'b000000100,
        P_EXTSKIP = 9'b000001000,
        P_FID     = 9'b000010000,
        P_FHDR    = 9'b000100000,
        P_PAY     = 9'b001000000,
        P_SKIP    = 9'b010000000,
        P_PEND    = 9'b100000000
    } parse_phase_t;

    class id3_record_scoreboard_t;
        parse_phase_t ph;
        logic [31:0]  cnt;
        logic [31:0]  body_sz;
        logic [31:0]  tflags;
        logic [31:0]  ver;
        logic [31:0]  pos;
        logic [31:0]  id_sh;
        logic [31:0]  sz_sh;
        logic [31:0]  fl_sh;
        logic [31:0]  nframes;
        logic         bad;
        record_t      want_records[$];
        int           errors;
        int           seen;

        function new();
            clear();
            errors = 0;
            seen   = 0;
        endfunction

        function int pending();
            return want_records.size();
        endfunction

        function void clear();
            ph      = P_HUNT;
            cnt     = 0;
            body_sz = 0;
            tflags  = 0;
            ver     = 0;
            pos     = 0;
            id_sh   = 0;
            sz_sh   = 0;
            fl_sh   = 0;
            nframes = 0;
            bad     = 1'b0;
        endfunction

        function logic [31:0] body_end();
            return HDR_LEN + body_sz;
        endfunction

        function logic [31:0] tag_end();
            return body_end() + (tflags[FLAG_FOOTER_BIT] ? FOOTER_LEN : 0);
        endfunction

        function void stop_frames(logic is_bad);
            if (is_bad)
            begin
                bad = 1'b1;
            end
            ph = P_SKIP;
        endfunction

        function void frame_start();
            if (body_end() - pos <= 4)
            begin
                stop_frames(1'b0);
            end
            else
            begin
                ph    = P_FID;
                cnt   = 0;
                id_sh = 0;
            end
        endfunction

        function void hunt(logic [7:0] b);
            id_sh = ((id_sh << 8) | b) & 32'h00FF_FFFF;
            if (id_sh == {8'h00, TAG_MAGIC})
            begin
                clear();
                ph  = P_HDR;
                pos = 3;
            end
        endfunction

        function record_t end_record();
            record_t     r;
            logic [31:0] t;
            r               = '0;
            t               = tag_end();
            r.record_kind   = bad ? REC_END_BAD : REC_END_OK;
            r.tag_version   = ver[7:0];
            r.tag_length    = t[28:0];
            r.frame_count   = nframes[15:0];
            return r;
        endfunction

        // Advance the parse by one accepted byte and queue any record it causes.
        function void note_byte(logic [7:0] b);
            logic [31:0] k;
            logic [31:0] rem;
            logic [31:0] skip;
            logic [31:0] t;
            logic        done;
            logic        dropped;
            logic        have;
            record_t     r;
            have    = 1'b0;
            dropped = 1'b0;
            r       = '0;
            case (ph)
                P_PEND:
                begin
                    r    = end_record();
                    have = 1'b1;
                    clear();
                    hunt(b);
                end
                P_HUNT:
                begin
                    hunt(b);
                end
                P_HDR:
                begin
                    k   = pos;
                    pos = pos + 1;
                    if (k == 3)
                        ver = b;
                    else if (k == 5)
                        tflags = b;
                    else if (k >= 6)
                        sz_sh = ((sz_sh << 7) | b[6:0]) & 32'h0FFF_FFFF;
                    if (k == 9)
                    begin
                        body_sz = sz_sh;
                        sz_sh   = 0;
                        if (ver < 2)
                        begin
                            stop_frames(1'b1);
                        end
                        else if (tflags[FLAG_EXT_BIT])
                        begin
                            if (body_end() - pos < 4)
                            begin
                                stop_frames(1'b1);
                            end
                            else
                            begin
                                ph  = P_EXT;
                                cnt = 0;
                            end
                        end
                        else
                        begin
                            frame_start();
                        end
                    end
                end
                P_EXT:
                begin
                    pos   = pos + 1;
                    sz_sh = ((sz_sh << 7) | b[6:0]) & 32'h0FFF_FFFF;
                    cnt   = cnt + 1;
                    if (cnt >= 4)
                    begin
                        skip = (sz_sh >= 4) ? sz_sh - 4 : 0;
                        if (skip > body_end() - pos)
                        begin
                            stop_frames(1'b1);
                        end
                        else if (skip == 0)
                        begin
                            frame_start();
                        end
                        else
                        begin
                            ph  = P_EXTSKIP;
                            cnt = skip;
                        end
                    end
                end
                P_EXTSKIP, P_PAY:
                begin
                    pos = pos + 1;
                    if (cnt > 0)
                        cnt = cnt - 1;
                    if (cnt == 0)
                        frame_start();
                end
                P_FID:
                begin
                    pos   = pos + 1;
                    id_sh = ((id_sh << 8) | b) & 32'h00FF_FFFF;
                    cnt   = cnt + 1;
                    if (cnt >= 3)
                    begin
                        if (id_sh == 0 || id_sh == {8'h00, FOOTER_MAGIC})
                        begin
                            stop_frames(1'b0);
                        end
                        else
                        begin
                            ph    = P_FHDR;
                            cnt   = 0;
                            sz_sh = 0;
                            fl_sh = 0;
                        end
                    end
                end
                P_FHDR:
                begin
                    pos = pos + 1;
                    k   = cnt;
                    cnt = cnt + 1;
                    if (ver == 2)
                    begin
                        sz_sh = (sz_sh << 8) | b;
                        done  = (cnt >= 3);
                    end
                    else
                    begin
                        done = (cnt >= 7);
                        if (k == 0)
                        begin
                            // drop a v2.3 frame whose fourth ID byte is zero
                            if (ver == 3 && b == 8'h00)
                            begin
                                frame_start();
                                dropped = 1'b1;
                            end
                            else
                            begin
                                id_sh = (id_sh << 8) | b;
                            end
                        end
                        else if (k <= 4)
                        begin
                            if (ver == 3)
                                sz_sh = (sz_sh << 8) | b;
                            else
                                sz_sh = (sz_sh << 7) | b[6:0];
                        end
                        else
                        begin
                            fl_sh = ((fl_sh << 8) | b) & 32'h0000_FFFF;
                        end
                    end
                    if (!dropped && !done)
                    begin
                        if (pos >= body_end())
                            stop_frames(1'b1);
                    end
                    else if (!dropped)
                    begin
                        if (ver == 2)
                            id_sh = id_sh << 8;
                        rem = body_end() - pos;
                        if (sz_sh > rem)
                        begin
                            stop_frames(1'b1);
                        end
                        else
                        begin
                            if (nframes < 32'h0000_FFFF)
                                nframes = nframes + 1;
                            t                = tag_end();
                            r.record_kind    = REC_FRAME;
                            r.frame_id       = id_sh;
                            if (id_sh[31:24] == ID_TEXT_LEAD || id_sh == ID_WXXX)
                                r.frame_kind = FK_TEXT;
                            else if (id_sh == ID_APIC)
                                r.frame_kind = FK_PICTURE;
                            else
                                r.frame_kind = FK_RAW;
                            r.frame_flags    = fl_sh[15:0];
                            r.frame_size     = sz_sh[27:0];
                            r.payload_offset = pos[28:0];
                            r.tag_version    = ver[7:0];
                            r.tag_length     = t[28:0];
                            r.frame_count    = nframes[15:0];
                            have             = 1'b1;
                            if (sz_sh == 0)
                            begin
                                frame_start();
                            end
                            else
                            begin
                                ph  = P_PAY;
                                cnt = sz_sh;
                            end
                        end
                    end
                end
                P_SKIP:
                begin
                    pos = pos + 1;
                end
                default:
                begin
                    clear();
                    hunt(b);
                end
            endcase

            // hold the tag end back one byte when a frame record already went out
            if (ph == P_SKIP && pos >= tag_end())
            begin
                if (!have)
                begin
                    r    = end_record();
                    have = 1'b1;
                    clear();
                end
                else
                begin
                    ph = P_PEND;
                end
            end
            if (have)
                want_records.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task cmp_field(string name, logic [31:0] got, logic [31:0] want_val);
            if (got !== want_val)
                report_mismatch($sformatf("record %0d %s: got %h, expected %h",
                                          seen, name, got, want_val));
        endtask

        task check_record(logic [159:0] d, logic [3:0] u);
            record_t want;
            seen++;
            if (want_records.size() == 0)
            begin
                report_mismatch($sformatf("record %0d arrived with nothing expected", seen));
                return;
            end
            want = want_records.pop_front();
            cmp_field("record_kind", u[1:0], want.record_kind);
            cmp_field("frame_kind", u[3:2], want.frame_kind);
            cmp_field("frame_id", d[31:0], want.frame_id);
            cmp_field("frame_flags", d[47:32], want.frame_flags);
            cmp_field("frame_size", d[75:48], want.frame_size);
            cmp_field("payload_offset", d[104:76], want.payload_offset);
            cmp_field("tag_version", d[112:105], want.tag_version);
            cmp_field("tag_length", d[141:113], want.tag_length);
            cmp_field("frame_count", d[157:142], want.frame_count);
        endtask
    endclass

    logic         clk;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [3:0]   m_tuser;

    id3_record_scoreboard_t sb;
    logic [7:0]   body[$];
    logic [7:0]   stream[$];
    bit           steady    = 1'b0;
    int           tag_bytes = 0;
    int           ntags     = 0;
    int           cycle_count = 0;

    id3v2_frame_header_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99, 0) >= 24);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_record(m_tdata, m_tuser);
        end
    end

    // Byte i of a syncsafe word; the ignored top bit is set now and then.
    function automatic logic [7:0] ss_byte(logic [31:0] v, int i);
        logic [7:0] r;
        r[6:0] = v[7 * i +: 7];
        r[7]   = ($urandom_range(99, 0) < 20);
        return r;
    endfunction

    function automatic void push_bytes(logic [31:0] w, int n);
        for (int i = 0; i < n; i++)
            body.push_back(w[31 - 8 * i -: 8]);
    endfunction

    function automatic void add_frame(logic [7:0] ver, logic [31:0] id, logic [31:0] claimed,
                                      int paylen, logic [15:0] fflags);
        push_bytes(id, (ver == 8'd2) ? 3 : 4);
        if (ver == 8'd2)
        begin
            for (int i = 2; i >= 0; i--)
                body.push_back(claimed[8 * i +: 8]);
        end
        else if (ver == 8'd3)
        begin
            for (int i = 3; i >= 0; i--)
                body.push_back(claimed[8 * i +: 8]);
        end
        else
        begin
            for (int i = 3; i >= 0; i--)
                body.push_back(ss_byte(claimed, i));
        end
        if (ver != 8'd2)
        begin
            body.push_back(fflags[15:8]);
            body.push_back(fflags[7:0]);
        end
        repeat (paylen) body.push_back(8'($urandom_range(255, 0)));
    endfunction

    function automatic logic [31:0] pick_id();
        logic [31:0] w;
        case ($urandom_range(9, 0))
            0: w = "TIT2";
            1: w = "TT2 ";
            2: w = ID_WXXX;
            3: w = ID_APIC;
            4: w = "PIC ";
            5: w = "PRIV";
            6: w = {ID_TEXT_LEAD, 24'($urandom)};
            7: w = $urandom;
            default: w = {8'($urandom_range(90, 65)), 8'($urandom_range(90, 65)),
                          8'($urandom_range(90, 65)), 8'($urandom_range(90, 48))};
        endcase
        return w;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99, 0) < 16)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_noise(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(99, 0);
            if (r < 15)
                send_byte(TAG_MAGIC[23:16]);
            else if (r < 30)
                send_byte(TAG_MAGIC[15:8]);
            else
                send_byte(8'($urandom_range(255, 0)));
        end
    endtask

    // Wrap the collected body in a tag header, and a footer if flagged, and send it.
    task automatic send_tag(input logic [7:0] ver, input logic [7:0] tflags, input int adj);
        int size;
        size = body.size() + adj;
        if (size < 0)
            size = 0;
        stream.push_back(TAG_MAGIC[23:16]);
        stream.push_back(TAG_MAGIC[15:8]);
        stream.push_back(TAG_MAGIC[7:0]);
        stream.push_back(ver);
        stream.push_back(8'($urandom_range(255, 0)));
        stream.push_back(tflags);
        for (int i = 3; i >= 0; i--)
            stream.push_back(ss_byte(size, i));
        stream = {stream, body};
        if (tflags[FLAG_FOOTER_BIT])
        begin
            stream.push_back(FOOTER_MAGIC[23:16]);
            stream.push_back(FOOTER_MAGIC[15:8]);
            stream.push_back(FOOTER_MAGIC[7:0]);
            stream.push_back(ver);
            stream.push_back(8'h00);
            stream.push_back(tflags);
            for (int i = 3; i >= 0; i--)
                stream.push_back(ss_byte(size, i));
        end
        body.delete();
        foreach (stream[i])
            send_byte(stream[i]);
        tag_bytes += stream.size();
        stream.delete();
    endtask

    task automatic drain_records();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic directed_tags();
        // partial magic just ahead of a real tag
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(TAG_MAGIC[23:16]);
        send_byte(TAG_MAGIC[15:8]);
        send_byte(TAG_MAGIC[23:16]);
        // v2.3: every frame kind, flag extremes, a zero-size frame, zero padding
        add_frame(8'd3, "TIT2", 3, 3, 16'h0000);
        add_frame(8'd3, ID_APIC, 2, 2, 16'hFFFF);
        add_frame(8'd3, ID_WXXX, 0, 0, 16'h8040);
        add_frame(8'd3, "PRIV", 1, 1, 16'h00FF);
        repeat (6) body.push_back(8'h00);
        send_tag(8'd3, 8'h00, 0);
        // v2.2: last zero-size frame ends on the same byte as the tag
        add_frame(8'd2, "TT2 ", 2, 2, 16'h0000);
        add_frame(8'd2, "PIC ", 0, 0, 16'h0000);
        send_tag(8'd2, 8'h00, 0);
        send_byte(8'h7E);
        // v2.4: extended header, syncsafe size above 127, footer, short padding
        for (int i = 3; i >= 0; i--)
            body.push_back(ss_byte(10, i));
        repeat (6) body.push_back(8'hC3);
        add_frame(8'd4, "TPE1", 130, 130, 16'h1234);
        repeat (3) body.push_back(8'h00);
        send_tag(8'd4, 8'h50, 0);
        // v2.3: short ID dropped, one frame, then the footer ID ends the frames
        push_bytes("TIT\0", 4);
        add_frame(8'd3, "COMM", 2, 2, 16'h0001);
        push_bytes({FOOTER_MAGIC, 8'h00}, 4);
        repeat (3) body.push_back(8'h00);
        send_tag(8'd3, 8'h00, 0);
        // versions below two
        repeat (4) body.push_back(8'($urandom_range(255, 0)));
        send_tag(8'd1, 8'h00, 0);
        send_tag(8'd0, 8'h10, 0);
        // empty body
        send_tag(8'd3, 8'h00, 0);
        // frame larger than what is left of the body
        add_frame(8'd3, "TXXX", 32'hFFFF_FFFF, 3, 16'h0000);
        send_tag(8'd3, 8'h00, 0);
        add_frame(8'd4, "GEOB", 32'h0FFF_FFFF, 3, 16'h0000);
        send_tag(8'd4, 8'h00, 0);
        add_frame(8'd2, "COM ", 32'h00FF_FFFF, 2, 16'h0000);
        send_tag(8'd2, 8'h00, 0);
        // extended size below four skips nothing
        for (int i = 3; i >= 0; i--)
            body.push_back(ss_byte(2, i));
        add_frame(8'd3, "TCON", 1, 1, 16'h0000);
        send_tag(8'd3, 8'h40, 0);
        // extended skip beyond the body
        for (int i = 3; i >= 0; i--)
            body.push_back(ss_byte(100, i));
        repeat (5) body.push_back(8'h11);
        send_tag(8'd4, 8'h40, 0);
        // no room for the extended size field
        body.push_back(8'h00);
        body.push_back(8'h00);
        send_tag(8'd3, 8'h40, 0);
        // frame header running past the body end
        push_bytes("TALB", 4);
        body.push_back(8'h00);
        body.push_back(8'h00);
        send_tag(8'd3, 8'h00, 0);
        // all-zero ID
        repeat (8) body.push_back(8'h00);
        send_tag(8'd4, 8'h10, 0);
        // top version byte takes the syncsafe layout
        add_frame(8'hFF, "TRCK", 4, 4, 16'hA5A5);
        send_tag(8'hFF, 8'hBF, 0);
        send_noise(3);
    endtask

    task automatic random_tag();
        logic [7:0]  ver;
        logic [7:0]  tflags;
        logic [31:0] claimed;
        int          r;
        int          adj;
        int          e;
        int          sz;
        adj = 0;
        r   = $urandom_range(99, 0);
        if (r < 30)
            ver = 8'd2;
        else if (r < 60)
            ver = 8'd3;
        else if (r < 88)
            ver = 8'd4;
        else if (r < 94)
            ver = 8'($urandom_range(1, 0));
        else
            ver = 8'($urandom_range(255, 5));
        tflags                  = 8'($urandom_range(255, 0));
        tflags[FLAG_EXT_BIT]    = ($urandom_range(99, 0) < 30);
        tflags[FLAG_FOOTER_BIT] = ($urandom_range(99, 0) < 30);
        if (tflags[FLAG_EXT_BIT])
        begin
            e = ($urandom_range(99, 0) < 85) ? $urandom_range(10, 4) : $urandom_range(3, 0);
            for (int i = 3; i >= 0; i--)
                body.push_back(ss_byte(e, i));
            repeat ((e > 4) ? e - 4 : 0) body.push_back(8'($urandom_range(255, 0)));
        end
        repeat ($urandom_range(5, 0))
        begin
            sz = ($urandom_range(99, 0) < 90) ? $urandom_range(6, 0) : $urandom_range(40, 7);
            add_frame(ver, pick_id(), sz, sz, 16'($urandom_range(65535, 0)));
        end
        // break about one tag in five
        if ($urandom_range(99, 0) < 20)
        begin
            case ($urandom_range(3, 0))
                0: adj = $urandom_range(20, 0) - 10;
                1:
                begin
                    sz      = $urandom_range(4, 0);
                    claimed = $urandom_range(1, 0) ? $urandom : sz + $urandom_range(300, 1);
                    add_frame(ver, pick_id(), claimed, sz, 16'($urandom_range(65535, 0)));
                end
                2: push_bytes({FOOTER_MAGIC, 8'h00}, 3);
                default: repeat ($urandom_range(8, 1)) body.push_back(8'($urandom_range(255, 0)));
            endcase
        end
        repeat ($urandom_range(6, 0)) body.push_back(8'h00);
        send_tag(ver, tflags, adj);
        send_noise($urandom_range(3, 0));
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_tags();
        drain_records();
        tag_bytes = 0;
        while (tag_bytes < RANDOM_BYTES)
        begin
            steady = (tag_bytes >= 250 && tag_bytes < 450);
            random_tag();
            ntags++;
            if (ntags % 6 == 0)
                drain_records();
        end
        steady = 1'b0;
        // flush a tag end held back by a frame record
        send_noise(4);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
